// ===== src/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key/value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CFG_W           = 5;
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SWEEP,
    ST_OUT
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
  } out_item_t;

  typedef struct packed {
    logic hit;
    logic old_found;
    logic free_found;
  } scan_status_t;

endpackage

// ===== src/lkvc_ram.sv =====
// ----------------------------------------------------------------------------
// lkvc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lkvc_scan.sv =====
// ----------------------------------------------------------------------------
// lkvc_scan
// shared compare unit: takes one slot per step and tracks the key match,
// the least recent valid slot and the first free slot
// ----------------------------------------------------------------------------
module lkvc_scan #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic                                 step_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]       slot_i,
  input  logic                                 slot_valid_i,
  input  logic [lkvc_pkg::DATA_W-1:0]          lookup_key_i,
  input  logic [lkvc_pkg::DATA_W-1:0]          key_i,
  input  logic [lkvc_pkg::DATA_W-1:0]          value_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]       rank_i,
  output lkvc_pkg::scan_status_t               status_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       hit_slot_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       hit_rank_o,
  output logic [lkvc_pkg::DATA_W-1:0]          hit_value_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       old_slot_o,
  output logic [lkvc_pkg::DATA_W-1:0]          old_key_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       free_slot_o
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);

  lkvc_pkg::scan_status_t        status_q, status_d;
  logic [IdxW-1:0]               hit_slot_q, hit_slot_d;
  logic [IdxW-1:0]               hit_rank_q, hit_rank_d;
  logic [lkvc_pkg::DATA_W-1:0]   hit_value_q, hit_value_d;
  logic [IdxW-1:0]               old_slot_q, old_slot_d;
  logic [IdxW-1:0]               old_rank_q, old_rank_d;
  logic [lkvc_pkg::DATA_W-1:0]   old_key_q, old_key_d;
  logic [IdxW-1:0]               free_slot_q, free_slot_d;
  logic                          key_eq;
  logic                          rank_gt;

  assign key_eq  = (key_i == lookup_key_i);
  assign rank_gt = (rank_i > old_rank_q);

  always_comb begin
    status_d    = status_q;
    hit_slot_d  = hit_slot_q;
    hit_rank_d  = hit_rank_q;
    hit_value_d = hit_value_q;
    old_slot_d  = old_slot_q;
    old_rank_d  = old_rank_q;
    old_key_d   = old_key_q;
    free_slot_d = free_slot_q;
    if (clear_i) begin
      status_d = '0;
    end else if (step_i) begin
      if (slot_valid_i) begin
        if (key_eq && !status_q.hit) begin
          status_d.hit = 1'b1;
          hit_slot_d   = slot_i;
          hit_rank_d   = rank_i;
          hit_value_d  = value_i;
        end
        if (!status_q.old_found || rank_gt) begin
          status_d.old_found = 1'b1;
          old_slot_d         = slot_i;
          old_rank_d         = rank_i;
          old_key_d          = key_i;
        end
      end else if (!status_q.free_found) begin
        status_d.free_found = 1'b1;
        free_slot_d         = slot_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
    end else begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    hit_rank_q  <= hit_rank_d;
    hit_value_q <= hit_value_d;
    old_slot_q  <= old_slot_d;
    old_rank_q  <= old_rank_d;
    old_key_q   <= old_key_d;
    free_slot_q <= free_slot_d;
  end

  assign status_o    = status_q;
  assign hit_slot_o  = hit_slot_q;
  assign hit_rank_o  = hit_rank_q;
  assign hit_value_o = hit_value_q;
  assign old_slot_o  = old_slot_q;
  assign old_key_o   = old_key_q;
  assign free_slot_o = free_slot_q;

endmodule

// ===== src/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value cache with least recently used replacement
// ----------------------------------------------------------------------------
// Items enter on in_valid_i/in_ready_o as a get or a put, results leave on
// out_valid_o/out_ready_i, one result per item, in order. cap_in_use is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the block is idle, which the block does not enforce. One item at a time:
// in_ready_o is high only while the sequencer is idle. A scan reads every
// slot once through the key, value and rank rams (one slot per cycle), then,
// except on a get miss, a rank sweep walks every slot again to update
// recency (one read-modify-write per cycle). The sequencer returns to idle
// as the result is registered, and the next item may then be accepted.
// The passes over the slots set how long an item takes: a get miss makes
// only the scan, a get hit or a put also the sweep.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item waits in the sequencer
// until the output register is free.
// Reset clears all valid marks, the entry count and the state machine and
// sets cap_in_use to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lkvc_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lkvc_pkg::out_item_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CapW = (CntW > lkvc_pkg::CFG_W) ? CntW : lkvc_pkg::CFG_W;
  localparam int unsigned DW   = lkvc_pkg::DATA_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);

  lkvc_pkg::state_e             state_q, state_d;
  lkvc_pkg::in_item_t           item_q, item_d;
  lkvc_pkg::out_item_t          res_q, res_d;
  lkvc_pkg::out_item_t          out_item_q, out_item_d;
  logic                         out_valid_q, out_valid_d;
  logic [lkvc_pkg::CFG_W-1:0]   cap_q;
  logic [MAX_ENTRIES-1:0]       valid_q, valid_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [IdxW-1:0]              pipe_idx_q;
  logic                         scan_step_q, sweep_step_q;
  logic                         scan_issue, sweep_issue, scan_clear;
  logic [IdxW-1:0]              target_q, target_d;
  logic [IdxW-1:0]              thr_q, thr_d;
  logic                         all_q, all_d;

  logic                         kv_we;
  logic [IdxW-1:0]              kv_waddr;
  logic [DW-1:0]                key_rdata, value_rdata;
  logic                         rank_we, rank_re;
  logic [IdxW-1:0]              rank_wdata, rank_rdata;

  lkvc_pkg::scan_status_t       status;
  logic [IdxW-1:0]              hit_slot, hit_rank, old_slot, free_slot;
  logic [DW-1:0]                hit_value, old_key;

  logic [CapW-1:0]              cap_ext, eff_cap;
  logic                         full;
  logic                         evict, insert;
  logic [IdxW-1:0]              new_slot;

  // effective capacity
  always_comb begin
    cap_ext = CapW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CapW'(1);
    end else if (cap_ext > CapW'(MAX_ENTRIES)) begin
      eff_cap = CapW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = (CapW'(count_q) >= eff_cap);
  assign evict  = full && status.old_found;
  assign insert = evict || status.free_found;

  always_comb begin
    if (evict) begin
      new_slot = (status.free_found && (free_slot < old_slot)) ? free_slot : old_slot;
    end else begin
      new_slot = free_slot;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    valid_d     = valid_q;
    count_d     = count_q;
    idx_d       = idx_q;
    target_d    = target_q;
    thr_d       = thr_q;
    all_d       = all_q;
    scan_issue  = 1'b0;
    sweep_issue = 1'b0;
    scan_clear  = 1'b0;
    kv_we       = 1'b0;
    kv_waddr    = hit_slot;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    in_ready_o  = (state_q == lkvc_pkg::ST_IDLE);

    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d     = in_item_i;
          idx_d      = '0;
          scan_clear = 1'b1;
          state_d    = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        scan_issue = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = lkvc_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      lkvc_pkg::ST_DRAIN: begin
        state_d = lkvc_pkg::ST_DECIDE;
      end
      lkvc_pkg::ST_DECIDE: begin
        idx_d                = '0;
        res_d.hit            = status.hit;
        res_d.read_value     = lkvc_pkg::MISS_VALUE;
        res_d.evicted        = 1'b0;
        res_d.evicted_key    = '0;
        target_d             = hit_slot;
        thr_d                = hit_rank;
        all_d                = 1'b0;
        if (item_q.cmd == lkvc_pkg::CMD_GET) begin
          if (status.hit) begin
            res_d.read_value = hit_value;
            state_d          = lkvc_pkg::ST_SWEEP;
          end else begin
            state_d = lkvc_pkg::ST_OUT;
          end
        end else if (status.hit) begin
          kv_we    = 1'b1;
          kv_waddr = hit_slot;
          state_d  = lkvc_pkg::ST_SWEEP;
        end else begin
          res_d.evicted = evict;
          if (evict) begin
            res_d.evicted_key = old_key;
            valid_d[old_slot] = 1'b0;
          end
          if (insert) begin
            kv_we             = 1'b1;
            kv_waddr          = new_slot;
            valid_d[new_slot] = 1'b1;
            target_d          = new_slot;
            all_d             = 1'b1;
            state_d           = lkvc_pkg::ST_SWEEP;
          end else begin
            state_d = lkvc_pkg::ST_OUT;
          end
          count_d = count_q - CntW'(evict) + CntW'(insert);
        end
      end
      lkvc_pkg::ST_SWEEP: begin
        sweep_issue = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = lkvc_pkg::ST_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      lkvc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lkvc_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      cap_q        <= lkvc_pkg::CAP_RESET;
      valid_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      scan_step_q  <= 1'b0;
      sweep_step_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      scan_step_q  <= scan_issue;
      sweep_step_q <= sweep_issue;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
    pipe_idx_q <= idx_q;
    target_q   <= target_d;
    thr_q      <= thr_d;
    all_q      <= all_d;
  end

  // rank update on read data of the sweep
  always_comb begin
    rank_re    = scan_issue || sweep_issue;
    rank_we    = 1'b0;
    rank_wdata = rank_rdata + 1'b1;
    if (sweep_step_q) begin
      if (pipe_idx_q == target_q) begin
        rank_we    = 1'b1;
        rank_wdata = '0;
      end else if (valid_q[pipe_idx_q] && (all_q || (rank_rdata < thr_q))) begin
        rank_we = 1'b1;
      end
    end
  end

  lkvc_ram #(
    .Width (DW),
    .Depth (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (item_q.key),
    .re_i    (scan_issue),
    .raddr_i (idx_q),
    .rdata_o (key_rdata)
  );

  lkvc_ram #(
    .Width (DW),
    .Depth (MAX_ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (item_q.value),
    .re_i    (scan_issue),
    .raddr_i (idx_q),
    .rdata_o (value_rdata)
  );

  lkvc_ram #(
    .Width (IdxW),
    .Depth (MAX_ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (pipe_idx_q),
    .wdata_i (rank_wdata),
    .re_i    (rank_re),
    .raddr_i (idx_q),
    .rdata_o (rank_rdata)
  );

  lkvc_scan #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .step_i       (scan_step_q),
    .slot_i       (pipe_idx_q),
    .slot_valid_i (valid_q[pipe_idx_q]),
    .lookup_key_i (item_q.key),
    .key_i        (key_rdata),
    .value_i      (value_rdata),
    .rank_i       (rank_rdata),
    .status_o     (status),
    .hit_slot_o   (hit_slot),
    .hit_rank_o   (hit_rank),
    .hit_value_o  (hit_value),
    .old_slot_o   (old_slot),
    .old_key_o    (old_key),
    .free_slot_o  (free_slot)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count above slot count");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("entry count differs from valid marks");

  a_put_miss_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_DECIDE) && (item_q.cmd == lkvc_pkg::CMD_PUT) && !status.hit
    |-> (status.free_found || status.old_found))
    else $error("put of a new key found neither a free nor an oldest slot");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lkvc_pkg::ST_OUT))
    else $error("result raised outside the output state");

endmodule
